/* hw/rtl/nhc_pkg.sv */
package nhc_pkg;

  localparam int unsigned SUM_W = 16;

  localparam logic [SUM_W-1:0] ADLER_MOD    = 16'd65521;
  localparam logic [SUM_W-1:0] LOW_SUM_INIT = 16'd1;
  localparam logic [SUM_W-1:0] HIGH_SUM_INIT = 16'd0;
  localparam logic [7:0]       DIM_LIMIT    = 8'd64;

  typedef logic [SUM_W-1:0] sum_t;

  // control from the byte stage to the sum registers
  typedef struct packed {
    logic advance;
    logic last;
  } nhc_ctl_t;

  // both operands stay below the modulus, so one conditional subtract is enough
  function automatic sum_t mod_add(input sum_t x, input logic [SUM_W:0] y);
    logic [SUM_W:0] s;
    s = {1'b0, x} + y;
    if (s >= {1'b0, ADLER_MOD}) begin
      s = s - {1'b0, ADLER_MOD};
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

/* hw/rtl/nhc_sum.sv */
module nhc_sum (
  input  logic              clk,
  input  logic              rst_n,
  input  nhc_pkg::nhc_ctl_t ctl,
  input  logic [7:0]        name_byte,
  output nhc_pkg::sum_t     low_nxt,
  output nhc_pkg::sum_t     high_nxt
);
  import nhc_pkg::*;

  sum_t low_sum_r;
  sum_t high_sum_r;

  always_comb begin
    low_nxt  = mod_add(low_sum_r, {{(SUM_W-8){1'b0}}, name_byte, 1'b0});
    high_nxt = mod_add(high_sum_r, {1'b0, low_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_sum_r  <= LOW_SUM_INIT;
      high_sum_r <= HIGH_SUM_INIT;
    end else if (ctl.advance) begin
      if (ctl.last) begin
        // name done, start over for the next one
        low_sum_r  <= LOW_SUM_INIT;
        high_sum_r <= HIGH_SUM_INIT;
      end else begin
        low_sum_r  <= low_nxt;
        high_sum_r <= high_nxt;
      end
    end
  end

endmodule

/* hw/rtl/nhc_color.sv */
module nhc_color (
  input  logic [31:0] checksum,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);
  import nhc_pkg::*;

  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic       dim;

  always_comb begin
    r   = checksum[7:0];
    g   = checksum[19:12];
    b   = checksum[27:20];
    dim = (r < DIM_LIMIT) && (g < DIM_LIMIT) && (b < DIM_LIMIT);
    if (dim) begin
      // all below 64, so the scaled values fit in 8 bits
      red   = r + {r[6:0], 1'b0};
      green = g + {g[6:0], 1'b0} + DIM_LIMIT;
      blue  = {b[5:0], 2'b00};
    end else begin
      red   = r;
      green = g;
      blue  = b;
    end
  end

endmodule

/* hw/rtl/name_hash_to_color.sv */
// Byte-serial name checksum and color. One name character is taken per transfer,
// the final one marked by in_last_byte; the block keeps an Adler-32 style pair of
// sums modulo 65521 with each byte added doubled, and on the marked byte gives one
// result: the 32-bit checksum (high sum in bits 31-16, low sum in 15-0) and a color
// taken from checksum bits, brightened when all three components are below 64.
// Unmarked bytes give no result. One byte is accepted per cycle unless the input is
// stalled as below; a byte passes an input register, then the modular adds and color
// logic, then the result register. The sums return to 1 and 0 after each name.
// Backpressure on the result side stalls the input only when a marked byte is
// waiting for the result register.
module name_hash_to_color (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_name_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_checksum,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);
  import nhc_pkg::*;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [31:0] checksum_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;

  logic       out_free;
  logic       s1_adv;
  logic       in_xfer;
  logic       res_load;
  nhc_ctl_t   ctl;
  sum_t       low_nxt;
  sum_t       high_nxt;
  logic [31:0] checksum_nxt;
  logic [7:0] red_nxt;
  logic [7:0] green_nxt;
  logic [7:0] blue_nxt;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    // unmarked bytes never need the result register
    s1_adv   = s1_valid_r && (!s1_last_r || out_free);
    in_ready = !s1_valid_r || s1_adv;
    in_xfer  = in_valid && in_ready;
    res_load = s1_adv && s1_last_r;

    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    ctl.advance  = s1_adv;
    ctl.last     = s1_last_r;
    checksum_nxt = {high_nxt, low_nxt};
  end

  nhc_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .name_byte (s1_byte_r),
    .low_nxt   (low_nxt),
    .high_nxt  (high_nxt)
  );

  nhc_color u_color (
    .checksum (checksum_nxt),
    .red      (red_nxt),
    .green    (green_nxt),
    .blue     (blue_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_name_byte;
      s1_last_r <= in_last_byte;
    end
    if (res_load) begin
      checksum_r <= checksum_nxt;
      red_r      <= red_nxt;
      green_r    <= green_nxt;
      blue_r     <= blue_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = checksum_r;
  assign out_red      = red_r;
  assign out_green    = green_r;
  assign out_blue     = blue_r;

endmodule

/* hw/rtl/nhc_checker.sv */
module nhc_props (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_checksum,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue
);
  import nhc_pkg::*;

  logic dim;

  assign dim = (out_checksum[7:0] < DIM_LIMIT) && (out_checksum[19:12] < DIM_LIMIT)
            && (out_checksum[27:20] < DIM_LIMIT);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_checksum))
    else $error("result changed while stalled");

  // both sums stay reduced
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_checksum[15:0] < ADLER_MOD) && (out_checksum[31:16] < ADLER_MOD))
    else $error("checksum half not reduced modulo 65521");

  // bright color is taken straight from checksum bits
  a_color_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !dim |-> (out_red == out_checksum[7:0]) &&
      (out_green == out_checksum[19:12]) && (out_blue == out_checksum[27:20]))
    else $error("plain color does not match checksum");

  // dim color is brightened
  a_color_dim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dim |-> (out_red == out_checksum[7:0] * 8'd3) &&
      (out_green == out_checksum[19:12] * 8'd3 + DIM_LIMIT) &&
      (out_blue == {out_checksum[25:20], 2'b00}))
    else $error("dim color not brightened");

endmodule

bind name_hash_to_color nhc_props u_nhc_props (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_checksum (out_checksum),
  .out_red      (out_red),
  .out_green    (out_green),
  .out_blue     (out_blue)
);
